// ----- rtl/rkw_pkg.sv -----
// Shared types and constants for the rotational keypoint warp block.
package rkw_pkg;
	localparam int PT_W   = 16;
	localparam int COEF_W = 32;
	localparam int DIM_W  = 13;
	localparam int QUO_W  = 16;

	typedef enum logic [1:0] {
		OUT_WARPED = 2'd0,
		OUT_BEHIND = 2'd1,
		OUT_OUTSIDE = 2'd2,
		OUT_BYPASS = 2'd3
	} outcome_t;

	typedef enum logic [3:0] {
		REG_PAIR_A = 4'd0,
		REG_PAIR_B = 4'd1,
		REG_PAIR_C = 4'd2,
		REG_PAIR_D = 4'd3,
		REG_LAST   = 4'd4,
		REG_WIDTH  = 4'd5,
		REG_HEIGHT = 4'd6,
		REG_BYPASS = 4'd7
	} reg_index_t;
endpackage

// ----- rtl/rkw_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module rkw_div import rkw_pkg::*; #(
	parameter int CW = 68
) (
	input  logic              clk,
	input  logic [CW-1:0]     num,
	input  logic [CW-1:0]     den,
	output logic [QUO_W-1:0]  quo
);
	logic [CW-1:0]    rem_s [QUO_W+1];
	logic [CW-1:0]    den_s [QUO_W+1];
	logic [QUO_W-1:0] quo_s [QUO_W+1];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		localparam int K = QUO_W - 1 - i;
		logic [CW:0] trial;
		assign trial = {1'b0, rem_s[i]} - {1'b0, (den_s[i] << K)};
		always_ff @(posedge clk) begin
			den_s[i+1] <= den_s[i];
			if (!trial[CW]) begin
				rem_s[i+1] <= trial[CW-1:0];
				quo_s[i+1] <= quo_s[i] | (QUO_W'(1) << K);
			end else begin
				rem_s[i+1] <= rem_s[i];
				quo_s[i+1] <= quo_s[i];
			end
		end
	end

	assign quo = quo_s[QUO_W];
endmodule

// ----- rtl/rotational_keypoint_warp_core.sv -----
// Top level of the rotational keypoint warp: homography warp of one keypoint per cycle.
// Usage:
//  - Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
//    register, cfg_data the value; cfg_ready is always high. Indexes above 7
//    are ignored. Write only while no item is in flight.
//  - Input: an item is accepted at a clock edge with start high and busy low.
//    busy stays low; a new item can enter every cycle.
//  - Output: result_valid is high for one cycle with pred_x, pred_y and
//    outcome; the receiver cannot stall.
//  - Stages from accept to result: products, sums, setup,
//    16 divider stages, final check. Throughput: one item per cycle.
//  - The 16 stage divider (one quotient bit per stage, both axes in
//    parallel) sets the latency.
//  - Reset clears all valid bits and loads the identity homography,
//    640 x 480 image and bypass off.
module rotational_keypoint_warp_core import rkw_pkg::*; #(
	parameter int FRACTION_BITS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [PT_W-1:0]   point_x,
	input  logic [PT_W-1:0]   point_y,
	output logic              result_valid,
	output logic [PT_W-1:0]   pred_x,
	output logic [PT_W-1:0]   pred_y,
	output logic [1:0]        outcome,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [3:0]        cfg_index,
	input  logic [63:0]       cfg_data
);
	localparam int PW  = COEF_W + PT_W + 1;
	localparam int SW  = PW + 3;
	localparam int CW  = SW + QUO_W;
	localparam int LW  = DIM_W + FRACTION_BITS;
	localparam int LAT = QUO_W;

	logic signed [COEF_W-1:0] h00_q, h01_q, h02_q, h10_q, h11_q, h12_q, h20_q, h21_q, h22_q;
	logic [DIM_W-1:0] width_q, height_q;
	logic             bypass_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h00_q <= COEF_W'(32'h10000); h01_q <= '0; h02_q <= '0;
			h10_q <= '0; h11_q <= COEF_W'(32'h10000); h12_q <= '0;
			h20_q <= '0; h21_q <= '0; h22_q <= COEF_W'(32'h10000);
			width_q  <= DIM_W'(640);
			height_q <= DIM_W'(480);
			bypass_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PAIR_A: begin h00_q <= cfg_data[63:32]; h01_q <= cfg_data[31:0]; end
				REG_PAIR_B: begin h02_q <= cfg_data[63:32]; h10_q <= cfg_data[31:0]; end
				REG_PAIR_C: begin h11_q <= cfg_data[63:32]; h12_q <= cfg_data[31:0]; end
				REG_PAIR_D: begin h20_q <= cfg_data[63:32]; h21_q <= cfg_data[31:0]; end
				REG_LAST:   h22_q    <= cfg_data[31:0];
				REG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				REG_BYPASS: bypass_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage 1: products
	logic v_s1;
	logic [PT_W-1:0] px_s1, py_s1;
	logic signed [PW-1:0] p00_s1, p01_s1, p10_s1, p11_s1, p20_s1, p21_s1;
	logic signed [PT_W:0] xs, ys;
	assign xs = $signed({1'b0, point_x});
	assign ys = $signed({1'b0, point_y});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start && !busy;
	end
	always_ff @(posedge clk) begin
		px_s1  <= point_x;
		py_s1  <= point_y;
		p00_s1 <= h00_q * xs; p01_s1 <= h01_q * ys;
		p10_s1 <= h10_q * xs; p11_s1 <= h11_q * ys;
		p20_s1 <= h20_q * xs; p21_s1 <= h21_q * ys;
	end

	// stage 2: sums
	logic v_s2;
	logic [PT_W-1:0] px_s2, py_s2;
	logic signed [SW-1:0] sx_s2, sy_s2, sz_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		px_s2 <= px_s1;
		py_s2 <= py_s1;
		sx_s2 <= SW'(p00_s1) + SW'(p01_s1) + (SW'(h02_q) <<< FRACTION_BITS);
		sy_s2 <= SW'(p10_s1) + SW'(p11_s1) + (SW'(h12_q) <<< FRACTION_BITS);
		sz_s2 <= SW'(p20_s1) + SW'(p21_s1) + (SW'(h22_q) <<< FRACTION_BITS);
	end

	// stage 3: classify and set up division
	logic [CW-1:0] nx_c, ny_c, dz_c;
	assign nx_c = CW'(sx_s2[SW-2:0]) << FRACTION_BITS;
	assign ny_c = CW'(sy_s2[SW-2:0]) << FRACTION_BITS;
	assign dz_c = CW'(sz_s2[SW-2:0]);

	logic v_s3;
	logic [PT_W-1:0] px_s3, py_s3;
	logic [CW-1:0] nx_s3, ny_s3, dz_s3;
	outcome_t pre_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		px_s3 <= px_s2;
		py_s3 <= py_s2;
		nx_s3 <= nx_c;
		ny_s3 <= ny_c;
		dz_s3 <= dz_c;
		if (bypass_q)
			pre_s3 <= OUT_BYPASS;
		else if (sz_s2 <= 0)
			pre_s3 <= OUT_BEHIND;
		else if (sx_s2 < 0 || sy_s2 < 0 || nx_c >= (dz_c << QUO_W) || ny_c >= (dz_c << QUO_W))
			pre_s3 <= OUT_OUTSIDE;
		else
			pre_s3 <= OUT_WARPED;
	end

	logic [QUO_W-1:0] qx, qy;
	rkw_div #(.CW(CW)) u_div_x (.clk(clk), .num(nx_s3), .den(dz_s3), .quo(qx));
	rkw_div #(.CW(CW)) u_div_y (.clk(clk), .num(ny_s3), .den(dz_s3), .quo(qy));

	// sideband alongside the divider
	logic            v_d  [LAT];
	logic [PT_W-1:0] px_d [LAT];
	logic [PT_W-1:0] py_d [LAT];
	outcome_t        pre_d [LAT];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) v_d[i] <= 1'b0;
		end else begin
			v_d[0] <= v_s3;
			for (int i = 1; i < LAT; i++) v_d[i] <= v_d[i-1];
		end
	end
	always_ff @(posedge clk) begin
		px_d[0] <= px_s3; py_d[0] <= py_s3; pre_d[0] <= pre_s3;
		for (int i = 1; i < LAT; i++) begin
			px_d[i]  <= px_d[i-1];
			py_d[i]  <= py_d[i-1];
			pre_d[i] <= pre_d[i-1];
		end
	end

	// final: bounds check and output register
	logic in_bounds;
	assign in_bounds = (LW'(qx) < (LW'(width_q) << FRACTION_BITS)) &&
	                   (LW'(qy) < (LW'(height_q) << FRACTION_BITS));

	outcome_t out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else         result_valid <= v_d[LAT-1];
	end
	always_ff @(posedge clk) begin
		if (pre_d[LAT-1] == OUT_WARPED && in_bounds) begin
			pred_x <= qx;
			pred_y <= qy;
			out_q  <= OUT_WARPED;
		end else begin
			pred_x <= px_d[LAT-1];
			pred_y <= py_d[LAT-1];
			out_q  <= (pre_d[LAT-1] == OUT_WARPED) ? OUT_OUTSIDE : pre_d[LAT-1];
		end
	end
	assign outcome = out_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(LAT+4) result_valid) else $error("item lost in pipeline");
	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && bypass_q) |-> (outcome == OUT_BYPASS)) else $error("bypass ignored");
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && outcome == OUT_WARPED) |->
		(32'(pred_x) < (32'(width_q) << FRACTION_BITS))) else $error("warped point outside");
endmodule
